// File: design/fpc_pkg.sv
package fpc_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CRCH = 3'd5,
        PH_CRCL = 3'd6
    } t_phase;

    // Status codes reported with every beat
    localparam logic [2:0] ST_WAIT    = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_HDR_ERR = 3'd2;
    localparam logic [2:0] ST_LEN_ERR = 3'd3;
    localparam logic [2:0] ST_CRC_ERR = 3'd4;

    // Frame sync bytes
    localparam logic [7:0] SYNC_A = 8'hA5;
    localparam logic [7:0] SYNC_B = 8'h5A;

    // CRC-16/Modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Length limit after reset
    localparam logic [7:0] MAX_LEN_RST = 8'd250;

endpackage

// File: design/fpc_crc8.sv
// One byte of CRC-16/Modbus: xor in the byte, then eight reflected shift steps.
module fpc_crc8 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ fpc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

// File: design/frame_parser_crc16_check.sv
// Frame parser with CRC-16/Modbus check.
//
// Input channel (i_in_valid / o_in_ready / i_rx_byte) takes one received byte
// per beat. Frames are A5 5A, command, length, data, CRC high, CRC low; the CRC
// covers header through data and is updated per byte, no frame buffer.
// Output channel (o_out_valid / i_out_ready) gives exactly one result beat per
// byte: status, data byte report with index, and the command and length of the
// current or last frame.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes max_data_len;
// it is always ready and must only be used while the block is idle.
//
// An input beat reaches its result beat through the input register, then the
// result register. Throughput: one byte per cycle while results are taken; the
// byte-wide CRC update and the phase step sit between the two registers.
// Reset (synchronous, active low) drops both registers, returns the parser to
// waiting for A5 and sets max_data_len to 250. When the receiver stalls, the
// result holds and one more byte waits in the input register; further bytes
// see o_in_ready low.
module frame_parser_crc16_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    // byte input
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    // result output
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic       o_data_valid,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_data_index,
    output logic [7:0] o_frame_cmd,
    output logic [7:0] o_frame_len
);

    // Configuration
    logic [7:0] r_max_len;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Parser state
    fpc_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi;

    // Result register
    logic       r_out_valid;
    logic [2:0] r_status, n_status;
    logic       r_dvalid, n_dvalid;
    logic [7:0] r_dbyte, n_dbyte;
    logic [7:0] r_dindex, n_dindex;

    logic        advance;
    logic [15:0] crc_fed;
    logic [15:0] crc_hdr_a;
    logic [15:0] crc_hdr_b;
    logic [7:0]  count_inc;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign count_inc   = r_count + 8'd1;

    // Running CRC with the byte in the input register
    fpc_crc8 u_crc_run (
        .i_crc  (r_crc),
        .i_byte (r_in_byte),
        .o_crc  (crc_fed)
    );

    // CRC of the sync bytes, constant inputs
    fpc_crc8 u_crc_hdr_a (
        .i_crc  (fpc_pkg::CRC_INIT),
        .i_byte (fpc_pkg::SYNC_A),
        .o_crc  (crc_hdr_a)
    );

    fpc_crc8 u_crc_hdr_b (
        .i_crc  (crc_hdr_a),
        .i_byte (fpc_pkg::SYNC_B),
        .o_crc  (crc_hdr_b)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= fpc_pkg::MAX_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    // Input register: load on accept, drop when passed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Phase step and result for the byte in the input register
    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_count  = r_count;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        n_status = fpc_pkg::ST_WAIT;
        n_dvalid = 1'b0;
        n_dbyte  = 8'h00;
        n_dindex = 8'h00;
        unique case (r_phase)
            fpc_pkg::PH_HDR0: begin
                if (r_in_byte == fpc_pkg::SYNC_A) begin
                    n_phase = fpc_pkg::PH_HDR1;
                end else begin
                    n_status = fpc_pkg::ST_HDR_ERR;
                end
            end
            fpc_pkg::PH_HDR1: begin
                // repeated A5 keeps waiting for 5A
                if (r_in_byte == fpc_pkg::SYNC_B) begin
                    n_phase = fpc_pkg::PH_CMD;
                    n_count = 8'h00;
                    n_cmd   = 8'h00;
                    n_len   = 8'h00;
                    n_crc   = crc_hdr_b;
                end else if (r_in_byte != fpc_pkg::SYNC_A) begin
                    n_phase = fpc_pkg::PH_HDR0;
                end
            end
            fpc_pkg::PH_CMD: begin
                n_cmd   = r_in_byte;
                n_crc   = crc_fed;
                n_phase = fpc_pkg::PH_LEN;
            end
            fpc_pkg::PH_LEN: begin
                n_len = r_in_byte;
                n_crc = crc_fed;
                priority if (r_in_byte == 8'h00) begin
                    n_phase = fpc_pkg::PH_CRCH;
                end else if (r_in_byte > r_max_len) begin
                    n_phase  = fpc_pkg::PH_HDR0;
                    n_status = fpc_pkg::ST_LEN_ERR;
                end else begin
                    n_phase = fpc_pkg::PH_DATA;
                    n_count = 8'h00;
                end
            end
            fpc_pkg::PH_DATA: begin
                n_dvalid = 1'b1;
                n_dbyte  = r_in_byte;
                n_dindex = r_count;
                n_crc    = crc_fed;
                n_count  = count_inc;
                if (count_inc >= r_len) begin
                    n_phase = fpc_pkg::PH_CRCH;
                end
            end
            fpc_pkg::PH_CRCH: begin
                n_crc_hi = r_in_byte;
                n_phase  = fpc_pkg::PH_CRCL;
            end
            fpc_pkg::PH_CRCL: begin
                n_status = ({r_crc_hi, r_in_byte} == r_crc) ? fpc_pkg::ST_OK
                                                             : fpc_pkg::ST_CRC_ERR;
                n_phase  = fpc_pkg::PH_HDR0;
            end
            default: begin
                n_phase = fpc_pkg::PH_HDR0;
            end
        endcase
    end

    // Parser state: advance together with the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= fpc_pkg::PH_HDR0;
            r_cmd    <= 8'h00;
            r_len    <= 8'h00;
            r_count  <= 8'h00;
            r_crc    <= fpc_pkg::CRC_INIT;
            r_crc_hi <= 8'h00;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status <= n_status;
            r_dvalid <= n_dvalid;
            r_dbyte  <= n_dbyte;
            r_dindex <= n_dindex;
        end
    end

    // Command and length only change when a new result loads
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_data_valid = r_dvalid;
    assign o_data_byte  = r_dbyte;
    assign o_data_index = r_dindex;
    assign o_frame_cmd  = r_cmd;
    assign o_frame_len  = r_len;

    // Data beats carry waiting status
    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_data_valid) |-> (o_status == fpc_pkg::ST_WAIT))
        else $error("data beat with non-waiting status");

    // Data index stays inside the frame length
    a_data_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_data_valid) |-> (o_data_index < o_frame_len))
        else $error("data index beyond frame length");

    // Non-data beats report zero byte and index
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_data_valid) |-> (o_data_byte == 8'h00 && o_data_index == 8'h00))
        else $error("data fields set on non-data beat");

    // Any final or error status leaves the parser hunting for A5
    a_end_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == fpc_pkg::ST_OK || o_status == fpc_pkg::ST_CRC_ERR ||
                         o_status == fpc_pkg::ST_LEN_ERR || o_status == fpc_pkg::ST_HDR_ERR))
        |-> (r_phase == fpc_pkg::PH_HDR0))
        else $error("parser not back at header after frame end");

endmodule
